// File: rtl/assert_macros.svh
// Assertion shorthands used by the checker module tqsc_check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define CHK_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("check failed");

// same-cycle implication
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("check failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("check failed");

`endif

// File: rtl/tqsc_pkg.sv
package tqsc_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int SCALE_FRAC_BITS = 12;
  localparam int SCALE_WIDTH     = 16;
  localparam int COLOR_WIDTH     = 32;
  localparam int CFG_ADDR_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH  = COORD_WIDTH;

  localparam int PROD_WIDTH  = COORD_WIDTH + SCALE_WIDTH + 1;
  localparam int SHIFT_WIDTH = PROD_WIDTH - SCALE_FRAC_BITS;
  localparam int REM_WIDTH   = COORD_WIDTH + 3;
  localparam int DIV_STEPS   = COORD_WIDTH + 1;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_SCALE_X     = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_SCALE_Y     = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_OFFSET_X    = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CLIP_LEFT   = 3'd4;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CLIP_TOP    = 3'd5;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CLIP_RIGHT  = 3'd6;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CLIP_BOTTOM = 3'd7;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;

  localparam logic [2:0] VTX_LAST = 3'd5;
  // per vertex: pick max corner (bit k = vertex k)
  localparam logic [5:0] VTX_X_HI = 6'b011010;
  localparam logic [5:0] VTX_Y_HI = 6'b110100;

  typedef logic signed [COORD_WIDTH-1:0]   coord_t;
  typedef logic signed [COORD_WIDTH:0]     wide_t;
  typedef logic        [COORD_WIDTH:0]     uwide_t;
  typedef logic signed [COORD_WIDTH+1:0]   sum_t;
  typedef logic signed [PROD_WIDTH-1:0]    prod_t;
  typedef logic signed [SHIFT_WIDTH-1:0]   shifted_t;
  typedef logic        [REM_WIDTH-1:0]     rem_t;
  typedef logic        [SCALE_WIDTH-1:0]   scale_t;
  typedef logic        [COLOR_WIDTH-1:0]   color_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam scale_t SCALE_ONE = scale_t'(1) << SCALE_FRAC_BITS;

  typedef struct packed {
    coord_t vmin;
    coord_t vmax;
    coord_t tmin;
    coord_t tmax;
    logic   cut;
    logic   neg;
    logic   drop;
    uwide_t mag;
    uwide_t num;
    uwide_t den;
    uwide_t rem;
    uwide_t quo;
  } axis_t;

  typedef struct packed {
    logic             valid;
    axis_t [1:0]      ax;
    coord_t           depth;
    color_t           color;
  } quad_t;

  typedef struct packed {
    logic             valid;
    prod_t [1:0]      p_lo;
    prod_t [1:0]      p_hi;
    coord_t [1:0]     t_lo;
    coord_t [1:0]     t_hi;
    coord_t           depth;
    color_t           color;
  } scaled_t;

  function automatic sum_t sx2(input coord_t v);
    sum_t r;
    begin
      r = {{2{v[COORD_WIDTH-1]}}, v};
      return r;
    end
  endfunction

  function automatic wide_t sx1(input coord_t v);
    wide_t r;
    begin
      r = {v[COORD_WIDTH-1], v};
      return r;
    end
  endfunction

  function automatic coord_t sat2(input sum_t v);
    sum_t hi;
    sum_t lo;
    begin
      hi = {3'b000, {(COORD_WIDTH-1){1'b1}}};
      lo = {3'b111, {(COORD_WIDTH-1){1'b0}}};
      if (v > hi) return COORD_MAX;
      else if (v < lo) return COORD_MIN;
      else return v[COORD_WIDTH-1:0];
    end
  endfunction

  function automatic coord_t sat_shift(input shifted_t v);
    shifted_t hi;
    shifted_t lo;
    begin
      hi = {{(SHIFT_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
      lo = {{(SHIFT_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
      if (v > hi) return COORD_MAX;
      else if (v < lo) return COORD_MIN;
      else return v[COORD_WIDTH-1:0];
    end
  endfunction

  function automatic prod_t mul_scale(input coord_t c, input scale_t s);
    prod_t a;
    prod_t b;
    begin
      a = {{(PROD_WIDTH-COORD_WIDTH){c[COORD_WIDTH-1]}}, c};
      b = {{(PROD_WIDTH-SCALE_WIDTH){1'b0}}, s};
      return a * b;
    end
  endfunction

  // floor shift, saturate, add offset, saturate
  function automatic coord_t scale_offset(input prod_t p, input coord_t off);
    prod_t  sh;
    coord_t sc;
    begin
      sh = p >>> SCALE_FRAC_BITS;
      sc = sat_shift(sh[SHIFT_WIDTH-1:0]);
      return sat2(sx2(sc) + sx2(off));
    end
  endfunction

  // load span magnitude, cut and size for one mul-div pass
  function automatic axis_t arm(input axis_t a, input uwide_t num);
    axis_t r;
    wide_t span;
    wide_t size;
    begin
      r    = a;
      span = sx1(a.tmax) - sx1(a.tmin);
      size = sx1(a.vmax) - sx1(a.vmin);
      r.neg = span[COORD_WIDTH];
      r.mag = span[COORD_WIDTH] ? uwide_t'(~span + 1'b1) : uwide_t'(span);
      r.num = num;
      r.den = uwide_t'(size);
      r.rem = '0;
      r.quo = '0;
      return r;
    end
  endfunction

  function automatic axis_t setup_lo(input axis_t a, input coord_t lo);
    axis_t  r;
    coord_t vmin;
    coord_t vmax;
    wide_t  c;
    begin
      vmin = a.vmin;
      vmax = a.vmax;
      c    = sx1(lo) - sx1(vmin);
      r    = arm(a, uwide_t'(c));
      r.cut  = lo > vmin;
      r.drop = a.drop | ((lo > vmin) & ~(lo < vmax));
      return r;
    end
  endfunction

  function automatic axis_t setup_hi(input axis_t a, input coord_t hi);
    axis_t  r;
    coord_t vmin;
    coord_t vmax;
    wide_t  c;
    begin
      vmin = a.vmin;
      vmax = a.vmax;
      c    = sx1(vmax) - sx1(hi);
      r    = arm(a, uwide_t'(c));
      r.cut  = vmax > hi;
      r.drop = a.drop | ((vmax > hi) & ~(vmin < hi));
      return r;
    end
  endfunction

  // one step of floor(mag * num / den), mag bit b taken msb first
  function automatic axis_t div_step(input axis_t a, input logic b);
    axis_t r;
    rem_t  t;
    rem_t  d1w;
    rem_t  d2w;
    logic  ge1;
    logic  ge2;
    rem_t  nr;
    begin
      r   = a;
      t   = {1'b0, a.rem, 1'b0} + (b ? {2'b00, a.num} : rem_t'(0));
      d1w = {2'b00, a.den};
      d2w = {1'b0, a.den, 1'b0};
      ge1 = t >= d1w;
      ge2 = t >= d2w;
      nr  = ge2 ? (t - d2w) : (ge1 ? (t - d1w) : t);
      r.rem = nr[COORD_WIDTH:0];
      r.quo = {a.quo[COORD_WIDTH-1:0], 1'b0} +
              {{(COORD_WIDTH-1){1'b0}}, ge2, ge1 & ~ge2};
      return r;
    end
  endfunction

  function automatic sum_t signed_quo(input axis_t a);
    sum_t q;
    begin
      q = {1'b0, a.quo};
      return a.neg ? -q : q;
    end
  endfunction

  function automatic axis_t apply_lo(input axis_t a, input coord_t lo);
    axis_t r;
    begin
      r = a;
      if (a.cut) begin
        r.tmin = sat2(sx2(a.tmin) + signed_quo(a));
        r.vmin = lo;
      end
      return r;
    end
  endfunction

  function automatic axis_t apply_hi(input axis_t a, input coord_t hi);
    axis_t r;
    begin
      r = a;
      if (a.cut) begin
        r.tmax = sat2(sx2(a.tmax) - signed_quo(a));
        r.vmax = hi;
      end
      return r;
    end
  endfunction

endpackage

// File: rtl/textured_quad_scale_clip_emit.sv
// Textured quad scale, offset and scissor clip with two-triangle emit. A quad
// request enters every cycle while in_stall is low, into a 72-stage pipeline
// (multiply, scale and offset, then for each clip side a setup stage, a
// 33-stage long-division pipeline that works out the texture shift and an
// apply stage), and the emitter's hold register is the output register. Each
// surviving quad leaves as six vertex requests, one per cycle while out_stall
// is low, so the vertex port sets the sustained rate; quads clipped away take
// no output slot. Configuration writes are always accepted and must only be
// issued while the block is empty.
module textured_quad_scale_clip_emit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tqsc_pkg::CFG_ADDR_WIDTH-1:0]   cfg_index,
  input  logic [tqsc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  tqsc_pkg::coord_t                      quad_left,
  input  tqsc_pkg::coord_t                      quad_top,
  input  tqsc_pkg::coord_t                      quad_right,
  input  tqsc_pkg::coord_t                      quad_bottom,
  input  tqsc_pkg::coord_t                      quad_depth,
  input  tqsc_pkg::coord_t                      tex_left,
  input  tqsc_pkg::coord_t                      tex_top,
  input  tqsc_pkg::coord_t                      tex_right,
  input  tqsc_pkg::coord_t                      tex_bottom,
  input  tqsc_pkg::color_t                      quad_color,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tqsc_pkg::coord_t                      vertex_x,
  output tqsc_pkg::coord_t                      vertex_y,
  output tqsc_pkg::coord_t                      vertex_z,
  output tqsc_pkg::color_t                      vertex_color,
  output tqsc_pkg::coord_t                      vertex_u,
  output tqsc_pkg::coord_t                      vertex_v,
  output logic                                  last_vertex
);

  tqsc_pkg::scale_t  scale   [2];
  tqsc_pkg::coord_t  offset  [2];
  tqsc_pkg::coord_t  clip_lo [2];
  tqsc_pkg::coord_t  clip_hi [2];

  tqsc_pkg::scaled_t s1, s1_next;
  tqsc_pkg::quad_t   s2, s2_next;
  tqsc_pkg::quad_t   s3, s3_next;
  tqsc_pkg::quad_t   lo_q;
  tqsc_pkg::quad_t   s4, s4_next;
  tqsc_pkg::quad_t   s5, s5_next;
  tqsc_pkg::quad_t   hi_q;
  tqsc_pkg::quad_t   s6, s6_next;

  logic adv;
  logic emit_ready;
  logic s6_live;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale[tqsc_pkg::AXIS_X]   <= tqsc_pkg::SCALE_ONE;
      scale[tqsc_pkg::AXIS_Y]   <= tqsc_pkg::SCALE_ONE;
      offset[tqsc_pkg::AXIS_X]  <= '0;
      offset[tqsc_pkg::AXIS_Y]  <= '0;
      clip_lo[tqsc_pkg::AXIS_X] <= tqsc_pkg::COORD_MIN;
      clip_lo[tqsc_pkg::AXIS_Y] <= tqsc_pkg::COORD_MIN;
      clip_hi[tqsc_pkg::AXIS_X] <= tqsc_pkg::COORD_MAX;
      clip_hi[tqsc_pkg::AXIS_Y] <= tqsc_pkg::COORD_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tqsc_pkg::REG_SCALE_X:     scale[tqsc_pkg::AXIS_X]   <= cfg_data[tqsc_pkg::SCALE_WIDTH-1:0];
        tqsc_pkg::REG_SCALE_Y:     scale[tqsc_pkg::AXIS_Y]   <= cfg_data[tqsc_pkg::SCALE_WIDTH-1:0];
        tqsc_pkg::REG_OFFSET_X:    offset[tqsc_pkg::AXIS_X]  <= cfg_data;
        tqsc_pkg::REG_OFFSET_Y:    offset[tqsc_pkg::AXIS_Y]  <= cfg_data;
        tqsc_pkg::REG_CLIP_LEFT:   clip_lo[tqsc_pkg::AXIS_X] <= cfg_data;
        tqsc_pkg::REG_CLIP_TOP:    clip_lo[tqsc_pkg::AXIS_Y] <= cfg_data;
        tqsc_pkg::REG_CLIP_RIGHT:  clip_hi[tqsc_pkg::AXIS_X] <= cfg_data;
        tqsc_pkg::REG_CLIP_BOTTOM: clip_hi[tqsc_pkg::AXIS_Y] <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiply
  always_comb begin
    s1_next.valid = in_valid;
    s1_next.p_lo[tqsc_pkg::AXIS_X] = tqsc_pkg::mul_scale(quad_left,   scale[tqsc_pkg::AXIS_X]);
    s1_next.p_hi[tqsc_pkg::AXIS_X] = tqsc_pkg::mul_scale(quad_right,  scale[tqsc_pkg::AXIS_X]);
    s1_next.p_lo[tqsc_pkg::AXIS_Y] = tqsc_pkg::mul_scale(quad_top,    scale[tqsc_pkg::AXIS_Y]);
    s1_next.p_hi[tqsc_pkg::AXIS_Y] = tqsc_pkg::mul_scale(quad_bottom, scale[tqsc_pkg::AXIS_Y]);
    s1_next.t_lo[tqsc_pkg::AXIS_X] = tex_left;
    s1_next.t_hi[tqsc_pkg::AXIS_X] = tex_right;
    s1_next.t_lo[tqsc_pkg::AXIS_Y] = tex_top;
    s1_next.t_hi[tqsc_pkg::AXIS_Y] = tex_bottom;
    s1_next.depth = quad_depth;
    s1_next.color = quad_color;
  end

  // shift, offset, saturate
  always_comb begin
    s2_next = '0;
    s2_next.valid = s1.valid;
    s2_next.depth = s1.depth;
    s2_next.color = s1.color;
    for (int k = 0; k < 2; k++) begin
      s2_next.ax[k].vmin = tqsc_pkg::scale_offset(s1.p_lo[k], offset[k]);
      s2_next.ax[k].vmax = tqsc_pkg::scale_offset(s1.p_hi[k], offset[k]);
      s2_next.ax[k].tmin = s1.t_lo[k];
      s2_next.ax[k].tmax = s1.t_hi[k];
    end
  end

  always_comb begin
    s3_next = s2;
    for (int k = 0; k < 2; k++) begin
      s3_next.ax[k] = tqsc_pkg::setup_lo(s2.ax[k], clip_lo[k]);
    end
  end

  tqsc_div u_div_lo (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   (s3),
    .q   (lo_q)
  );

  always_comb begin
    s4_next = lo_q;
    for (int k = 0; k < 2; k++) begin
      s4_next.ax[k] = tqsc_pkg::apply_lo(lo_q.ax[k], clip_lo[k]);
    end
  end

  always_comb begin
    s5_next = s4;
    for (int k = 0; k < 2; k++) begin
      s5_next.ax[k] = tqsc_pkg::setup_hi(s4.ax[k], clip_hi[k]);
    end
  end

  tqsc_div u_div_hi (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   (s5),
    .q   (hi_q)
  );

  always_comb begin
    s6_next = hi_q;
    for (int k = 0; k < 2; k++) begin
      s6_next.ax[k] = tqsc_pkg::apply_hi(hi_q.ax[k], clip_hi[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      s5.valid <= 1'b0;
      s6.valid <= 1'b0;
    end else if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
    end
  end

  // clipped-away quads drain without waiting on the emitter
  assign s6_live  = s6.valid & ~(s6.ax[tqsc_pkg::AXIS_X].drop | s6.ax[tqsc_pkg::AXIS_Y].drop);
  assign adv      = ~s6_live | emit_ready;
  assign in_stall = ~adv;

  tqsc_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .item         (s6),
    .ready        (emit_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .vertex_color (vertex_color),
    .vertex_u     (vertex_u),
    .vertex_v     (vertex_v),
    .last_vertex  (last_vertex)
  );

endmodule

// File: rtl/tqsc_div.sv
module tqsc_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  tqsc_pkg::quad_t d,
  output tqsc_pkg::quad_t q
);

  tqsc_pkg::quad_t src [tqsc_pkg::DIV_STEPS];
  tqsc_pkg::quad_t nxt [tqsc_pkg::DIV_STEPS];
  tqsc_pkg::quad_t st  [tqsc_pkg::DIV_STEPS];

  always_comb begin
    src[0] = d;
    for (int j = 1; j < tqsc_pkg::DIV_STEPS; j++) begin
      src[j] = st[j-1];
    end
    for (int j = 0; j < tqsc_pkg::DIV_STEPS; j++) begin
      nxt[j] = src[j];
      for (int k = 0; k < 2; k++) begin
        nxt[j].ax[k] = tqsc_pkg::div_step(src[j].ax[k],
                         src[j].ax[k].mag[tqsc_pkg::DIV_STEPS-1-j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < tqsc_pkg::DIV_STEPS; j++) begin
        st[j].valid <= 1'b0;
      end
    end else if (en) begin
      for (int j = 0; j < tqsc_pkg::DIV_STEPS; j++) begin
        st[j] <= nxt[j];
      end
    end
  end

  assign q = st[tqsc_pkg::DIV_STEPS-1];

endmodule

// File: rtl/tqsc_emit.sv
module tqsc_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  tqsc_pkg::quad_t        item,
  output logic                   ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tqsc_pkg::coord_t       vertex_x,
  output tqsc_pkg::coord_t       vertex_y,
  output tqsc_pkg::coord_t       vertex_z,
  output tqsc_pkg::color_t       vertex_color,
  output tqsc_pkg::coord_t       vertex_u,
  output tqsc_pkg::coord_t       vertex_v,
  output logic                   last_vertex
);

  logic            busy;
  logic [2:0]      cnt;
  tqsc_pkg::quad_t hold;
  logic            fire;
  logic            load;
  logic            xh;
  logic            yh;

  assign fire  = busy & ~out_stall;
  assign last_vertex = cnt == tqsc_pkg::VTX_LAST;
  assign ready = ~busy | (fire & last_vertex);
  assign load  = item.valid & ~(item.ax[tqsc_pkg::AXIS_X].drop |
                                item.ax[tqsc_pkg::AXIS_Y].drop) & ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (fire) begin
      if (last_vertex) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= item;
    end
  end

  assign xh = tqsc_pkg::VTX_X_HI[cnt];
  assign yh = tqsc_pkg::VTX_Y_HI[cnt];

  assign out_valid    = busy;
  assign vertex_x     = xh ? hold.ax[tqsc_pkg::AXIS_X].vmax : hold.ax[tqsc_pkg::AXIS_X].vmin;
  assign vertex_u     = xh ? hold.ax[tqsc_pkg::AXIS_X].tmax : hold.ax[tqsc_pkg::AXIS_X].tmin;
  assign vertex_y     = yh ? hold.ax[tqsc_pkg::AXIS_Y].vmax : hold.ax[tqsc_pkg::AXIS_Y].vmin;
  assign vertex_v     = yh ? hold.ax[tqsc_pkg::AXIS_Y].tmax : hold.ax[tqsc_pkg::AXIS_Y].tmin;
  assign vertex_z     = hold.depth;
  assign vertex_color = hold.color;

endmodule

// File: rtl/tqsc_check.sv
`include "assert_macros.svh"

module tqsc_check (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             cfg_ready,
  input tqsc_pkg::coord_t vertex_x,
  input tqsc_pkg::coord_t vertex_z,
  input tqsc_pkg::color_t vertex_color,
  input logic             last_vertex
);

  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(vertex_x))
  `CHK_NEXT(a_burst, clk, rst, out_valid && !out_stall && !last_vertex, out_valid)
  `CHK_NEXT(a_same_quad, clk, rst, out_valid && !out_stall && !last_vertex, $stable(vertex_z) && $stable(vertex_color))
  `CHK_IMPL(a_idle_open, clk, rst, !out_valid && in_valid, !in_stall)
  `CHK_ALWAYS(a_cfg_open, clk, rst, cfg_ready)

endmodule

bind textured_quad_scale_clip_emit tqsc_check u_check (.*);

// File: verif/quad_vertex_checker.sv
`timescale 1ns / 1ps
module quad_vertex_checker
  import tqsc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_ADDR_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  coord_t                     quad_left,
  input  coord_t                     quad_top,
  input  coord_t                     quad_right,
  input  coord_t                     quad_bottom,
  input  coord_t                     quad_depth,
  input  coord_t                     tex_left,
  input  coord_t                     tex_top,
  input  coord_t                     tex_right,
  input  coord_t                     tex_bottom,
  input  color_t                     quad_color,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  coord_t                     vertex_x,
  input  coord_t                     vertex_y,
  input  coord_t                     vertex_z,
  input  color_t                     vertex_color,
  input  coord_t                     vertex_u,
  input  coord_t                     vertex_v,
  input  logic                       last_vertex,
  output int                         errors,
  output int                         pending,
  output int                         vertices_seen,
  output int                         quads_dropped
);

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    color_t color;
    coord_t u;
    coord_t v;
    logic   last;
  } vertex_t;

  vertex_t vertex_q[$];

  longint sc_x, sc_y, off_x, off_y, cl_l, cl_t, cl_r, cl_b;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint place(longint c, longint s, longint off);
    longint p;
    p = c * s;
    return clamp32(clamp32(p >>> SCALE_FRAC_BITS) + off);
  endfunction

  // span * cut / size, magnitude truncated, sign of span
  function automatic longint tex_move(longint tlo, longint thi, longint cut, longint size);
    longint span;
    bit [127:0] mag;
    bit [127:0] q;
    span = thi - tlo;
    mag = (span < 0) ? 128'(-span) : 128'(span);
    q = (mag * 128'(cut)) / 128'(size);
    return (span < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit trim_axis(inout longint vmin, inout longint vmax,
                                   inout longint tmin, inout longint tmax,
                                   input longint lo, input longint hi);
    if (lo > vmin) begin
      if (lo < vmax) begin
        tmin = clamp32(tmin + tex_move(tmin, tmax, lo - vmin, vmax - vmin));
        vmin = lo;
      end else return 0;
    end
    if (vmax > hi) begin
      if (vmin < hi) begin
        tmax = clamp32(tmax - tex_move(tmin, tmax, vmax - hi, vmax - vmin));
        vmax = hi;
      end else return 0;
    end
    return 1;
  endfunction

  task automatic predict_quad();
    longint x0, y0, x1, y1, u0, v0, u1, v1;
    vertex_t vt;
    logic [5:0] xhi, yhi;
    x0 = place(longint'(quad_left), sc_x, off_x);
    y0 = place(longint'(quad_top), sc_y, off_y);
    x1 = place(longint'(quad_right), sc_x, off_x);
    y1 = place(longint'(quad_bottom), sc_y, off_y);
    u0 = longint'(tex_left);
    v0 = longint'(tex_top);
    u1 = longint'(tex_right);
    v1 = longint'(tex_bottom);
    if (!trim_axis(x0, x1, u0, u1, cl_l, cl_r) || !trim_axis(y0, y1, v0, v1, cl_t, cl_b)) begin
      quads_dropped++;
      return;
    end
    xhi = 6'b011010;
    yhi = 6'b110100;
    for (int k = 0; k < 6; k++) begin
      vt.x = coord_t'(xhi[k] ? x1 : x0);
      vt.u = coord_t'(xhi[k] ? u1 : u0);
      vt.y = coord_t'(yhi[k] ? y1 : y0);
      vt.v = coord_t'(yhi[k] ? v1 : v0);
      vt.z = quad_depth;
      vt.color = quad_color;
      vt.last = (k == 5);
      vertex_q.push_back(vt);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp, act);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sc_x <= 4096; sc_y <= 4096; off_x <= 0; off_y <= 0;
      cl_l <= -64'sd2147483648; cl_t <= -64'sd2147483648;
      cl_r <= 64'sd2147483647; cl_b <= 64'sd2147483647;
      errors <= 0; vertices_seen <= 0; quads_dropped <= 0;
      vertex_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE_X:     sc_x  = longint'(cfg_data[15:0]);
          REG_SCALE_Y:     sc_y  = longint'(cfg_data[15:0]);
          REG_OFFSET_X:    off_x = longint'(signed'(cfg_data));
          REG_OFFSET_Y:    off_y = longint'(signed'(cfg_data));
          REG_CLIP_LEFT:   cl_l  = longint'(signed'(cfg_data));
          REG_CLIP_TOP:    cl_t  = longint'(signed'(cfg_data));
          REG_CLIP_RIGHT:  cl_r  = longint'(signed'(cfg_data));
          REG_CLIP_BOTTOM: cl_b  = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_quad();
      if (out_valid && !out_stall) begin
        vertices_seen++;
        if (vertex_q.size() == 0) begin
          errors++;
          $display("%0t unexpected vertex x=%h y=%h", $time, vertex_x, vertex_y);
        end else begin
          vertex_t e;
          e = vertex_q.pop_front();
          check_field("vertex_x", e.x, vertex_x);
          check_field("vertex_y", e.y, vertex_y);
          check_field("vertex_z", e.z, vertex_z);
          check_field("vertex_color", e.color, vertex_color);
          check_field("vertex_u", e.u, vertex_u);
          check_field("vertex_v", e.v, vertex_v);
          check_field("last_vertex", 32'(e.last), 32'(last_vertex));
        end
      end
    end
  end

  assign pending = vertex_q.size();

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import tqsc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_ADDR_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  coord_t quad_left = '0, quad_top = '0, quad_right = '0, quad_bottom = '0, quad_depth = '0;
  coord_t tex_left = '0, tex_top = '0, tex_right = '0, tex_bottom = '0;
  color_t quad_color = '0;
  logic out_valid;
  logic out_stall = 0;
  coord_t vertex_x, vertex_y, vertex_z, vertex_u, vertex_v;
  color_t vertex_color;
  logic last_vertex;
  int errors, pending, vertices_seen, quads_dropped;

  int quads_sent = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int quiet = 0;

  localparam int UNIT = 65536;
  localparam int QUIET_LIMIT = 20000;

  always #5 clk = ~clk;

  textured_quad_scale_clip_emit uut (.*);
  quad_vertex_checker chk (.*);

  function automatic bit calm();
    return quads_sent >= 100 && quads_sent < 140;
  endfunction

  always @(posedge clk) begin
    if (!hold_done && quads_sent == 60) begin
      hold_done <= 1;
      hold_left <= 400;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= !calm() && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > QUIET_LIMIT) begin
      $display("%0t watchdog: no progress", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_WIDTH-1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_regs(int sx, int sy, int ox, int oy, int cl, int ct, int cr, int cb);
    drain();
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_CLIP_LEFT, cl);
    write_reg(REG_CLIP_TOP, ct);
    write_reg(REG_CLIP_RIGHT, cr);
    write_reg(REG_CLIP_BOTTOM, cb);
    cfg_valid <= 0;
  endtask

  task automatic send_quad(int l, int t, int r, int b, int ul, int vt, int ur, int vb);
    if (!calm() && $urandom_range(99) < 8) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    quad_left <= l; quad_top <= t; quad_right <= r; quad_bottom <= b;
    tex_left <= ul; tex_top <= vt; tex_right <= ur; tex_bottom <= vb;
    quad_depth <= $urandom;
    quad_color <= $urandom;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quads_sent++;
  endtask

  function automatic int near(int span);
    return $urandom_range(0, 2 * span) * UNIT - span * UNIT + $urandom_range(0, UNIT - 1);
  endfunction

  task automatic random_quads(int n);
    int l, t, r, b, sw;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        send_quad($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      end else begin
        l = near(120); r = near(120); t = near(120); b = near(120);
        if ($urandom_range(9) != 0 && l > r) begin sw = l; l = r; r = sw; end
        if ($urandom_range(9) != 0 && t > b) begin sw = t; t = b; b = sw; end
        if ($urandom_range(1))
          send_quad(l, t, r, b, $urandom, $urandom, $urandom, $urandom);
        else
          send_quad(l, t, r, b, near(300), near(300), near(300), near(300));
      end
    end
    in_valid <= 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // clipping off: extremes and an inverted quad
    send_quad(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_quad(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              0, 0, -1, -1);
    send_quad(0, 0, 0, 0, 32'hffffffff, 0, 32'h55555555, 32'haaaaaaaa);
    random_quads(5);

    set_regs(8192, 2048, 10 * UNIT, -5 * UNIT, -50 * UNIT, -40 * UNIT, 60 * UNIT, 30 * UNIT);
    // cut left, right, both, top, bottom
    send_quad(-40 * UNIT, 0, 0, UNIT, 0, 0, 100 * UNIT, UNIT);
    send_quad(0, 0, 40 * UNIT, UNIT, 100 * UNIT, 0, 0, UNIT);
    send_quad(-100 * UNIT, -100 * UNIT, 100 * UNIT, 100 * UNIT,
              32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_quad(0, -90 * UNIT, UNIT, 0, 0, 7 * UNIT, UNIT, -3 * UNIT);
    send_quad(0, 0, UNIT, 90 * UNIT, 0, -3 * UNIT, UNIT, 5 * UNIT);
    // touching rejects on each side
    send_quad(-40 * UNIT, 0, -30 * UNIT, UNIT, 0, 0, UNIT, UNIT);
    send_quad(25 * UNIT, 0, 40 * UNIT, UNIT, 0, 0, UNIT, UNIT);
    send_quad(0, -90 * UNIT, UNIT, -70 * UNIT, 0, 0, UNIT, UNIT);
    send_quad(0, 70 * UNIT, UNIT, 90 * UNIT, 0, 0, UNIT, UNIT);
    // an inverted quad inside the window, then a quad left of the window
    send_quad(10 * UNIT, 10 * UNIT, 0, 0, 0, 0, UNIT, UNIT);
    send_quad(-100 * UNIT, 0, -90 * UNIT + 5, UNIT, 0, 0, UNIT, UNIT);
    random_quads(90);

    set_regs(65535, 65535, 32'h7fffffff, 32'h80000000,
             32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    random_quads(15);
    set_regs(0, 0, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
    random_quads(8);
    set_regs(4096, 4096, 0, 0, 30 * UNIT, 30 * UNIT, -30 * UNIT, -30 * UNIT);
    random_quads(10);
    set_regs($urandom_range(1024, 12288), $urandom_range(1024, 12288), near(20), near(20),
             -$urandom_range(20, 100) * UNIT, -$urandom_range(20, 100) * UNIT,
             $urandom_range(20, 100) * UNIT, $urandom_range(20, 100) * UNIT);
    random_quads(60);

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d quads over six register settings; %0d vertices checked, %0d quads clipped away",
             quads_sent, vertices_seen, quads_dropped);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tqsc_pkg.sv
rtl/tqsc_div.sv
rtl/tqsc_emit.sv
rtl/textured_quad_scale_clip_emit.sv
rtl/tqsc_check.sv
verif/quad_vertex_checker.sv
verif/tb.sv
